// ----- rtl/bafw_pkg.sv -----
// Shared constants for the bit array field writer: field widths, stream
// layouts and reset values. No dependencies.
`default_nettype none

package bafw_pkg;

  // Field widths
  localparam int WORD_W  = 64;
  localparam int POS_W   = 17;
  localparam int IDX_W   = 16;
  localparam int WDT_W   = 7;
  localparam int OFF_W   = 6;
  localparam int WIDX_W  = 11;
  localparam int CFG_W   = 11;

  // Stream layouts, padded to whole bytes
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 152;

  // Reset values and limits
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;
  localparam logic [POS_W-1:0] POS_MAX   = 17'd65536;
  localparam logic [WDT_W-1:0] WDT_MAX   = 7'd64;

  // Result status codes
  localparam logic STATUS_WRITTEN = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

endpackage : bafw_pkg

`default_nettype wire

// ----- rtl/bit_array_field_writer_top.sv -----
// Bit array field writer: packs variable-width values into a banked store of
// 64-bit words. Depends on bafw_pkg.
`default_nettype none

// Each request places up to 64 bits of value either at the running bit
// position (mode 0) or at bit_index (mode 1), possibly straddling two words.
// The store is split into an even-word bank and an odd-word bank so both
// touched words are read together. On acceptance a request issues the
// synchronous reads of both banks; then, in the merge step, it merges the
// value, writes both banks back and loads the result register. Requests are
// taken while a result still waits in the output register; a waiting result
// stalls only the merge step. After reset a clearing pass zeroes one row of
// both banks per cycle until every row is clear, during which no request is
// taken; configuration writes are taken at any time. A request whose first
// word, or whose spilled word, lies at or beyond the effective capacity (the
// smaller of capacity_words and CAPACITY_WORDS) is refused: nothing is
// written and the position holds.
module bit_array_field_writer_top #(
  parameter int CAPACITY_WORDS = 1024
) (
  input  wire                            clk,
  input  wire                            rst_n,
  // Configuration: capacity_words
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [bafw_pkg::CFG_W-1:0]     cfg_data,
  // Input stream
  input  wire                            in_tvalid,
  output logic                           in_tready,
  // [15:0] bit_index, [79:16] value, [86:80] width, [87] zero
  input  wire  [bafw_pkg::IN_TDATA_W-1:0] in_tdata,
  // [0] mode
  input  wire                            in_tuser,
  // Result stream
  output logic                           out_tvalid,
  input  wire                            out_tready,
  // [16:0] position_after, [80:17] first_word_after,
  // [144:81] second_word_after, [145] spilled, [151:146] zero
  output logic [bafw_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] status
  output logic                           out_tuser
);
  import bafw_pkg::*;

  // Only words up to index 1024 can ever be written
  localparam int MEM_DEPTH = (CAPACITY_WORDS < 1025) ? CAPACITY_WORDS : 1025;
  localparam int ROWS      = (MEM_DEPTH + 1) / 2;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CAP_CLIP  = (CAPACITY_WORDS < 2047) ? CAPACITY_WORDS : 2047;
  localparam logic [CFG_W-1:0] CAP_LIM  = CAP_CLIP[CFG_W-1:0];
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_MODIFY
  } state_t;

  state_t               state_r;
  logic [CFG_W-1:0]     cap_r;
  logic [POS_W-1:0]     pos_r;
  logic [ROW_W-1:0]     clr_row_r;

  // Request held across the read cycle
  logic [WORD_W-1:0]    val_r;
  logic [OFF_W-1:0]     off_r;
  logic                 par_r;
  logic                 spill_r;
  logic                 refuse_r;
  logic [WDT_W-1:0]     wdt_r;
  logic [ROW_W-1:0]     even_addr_r;
  logic [ROW_W-1:0]     odd_addr_r;

  // Result register
  logic                 out_valid_r;
  logic                 status_r;
  logic [POS_W-1:0]     pos_out_r;
  logic [WORD_W-1:0]    first_out_r;
  logic [WORD_W-1:0]    second_out_r;
  logic                 spilled_out_r;

  // Banks
  logic [WORD_W-1:0]    mem_even [ROWS];
  logic [WORD_W-1:0]    mem_odd  [ROWS];
  logic [WORD_W-1:0]    even_q;
  logic [WORD_W-1:0]    odd_q;

  // Decode the incoming request
  logic                 in_fire;
  logic                 in_mode;
  logic [IDX_W-1:0]     in_idx;
  logic [WDT_W-1:0]     in_wdt_raw;
  logic [WDT_W-1:0]     in_wdt;
  logic [POS_W-1:0]     target;
  logic [WIDX_W-1:0]    widx;
  logic [OFF_W-1:0]     off;
  logic [WDT_W:0]       span;
  logic                 spill;
  logic [CFG_W-1:0]     cap_eff;
  logic [CFG_W:0]       widx_next;
  logic                 refuse;
  logic [WIDX_W-1:0]    row_a;
  logic [WIDX_W-1:0]    row_b;
  logic [ROW_W-1:0]     even_addr;
  logic [ROW_W-1:0]     odd_addr;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign in_mode    = in_tuser;
  assign in_idx     = in_tdata[15:0];
  assign in_wdt_raw = in_tdata[86:80];
  assign in_wdt     = (in_wdt_raw > WDT_MAX) ? WDT_MAX : in_wdt_raw;
  assign target     = in_mode ? {1'b0, in_idx} : pos_r;
  assign widx       = target[POS_W-1:OFF_W];
  assign off        = target[OFF_W-1:0];
  assign span       = {1'b0, in_wdt} + {2'b00, off};
  assign spill      = span > {1'b0, WDT_MAX};
  assign cap_eff    = (cap_r > CAP_LIM) ? CAP_LIM : cap_r;
  assign widx_next  = {1'b0, widx} + 12'd1;
  assign refuse     = (widx >= cap_eff) || (spill && (widx_next >= {1'b0, cap_eff}));

  // Word pair to rows: the even word of the pair may sit one row up
  assign row_a     = {1'b0, widx[WIDX_W-1:1]};
  assign row_b     = row_a + 11'd1;
  assign odd_addr  = row_a[ROW_W-1:0];
  assign even_addr = widx[0] ? row_b[ROW_W-1:0] : row_a[ROW_W-1:0];

  // Merge step
  logic                 out_free;
  logic                 do_modify;
  logic [WORD_W-1:0]    first_old;
  logic [WORD_W-1:0]    second_old;
  logic [WORD_W-1:0]    low_mask;
  logic [WORD_W-1:0]    first_new;
  logic [WORD_W-1:0]    second_new;
  logic [POS_W:0]       pos_sum;
  logic [POS_W-1:0]     pos_adv;

  assign out_free   = !out_valid_r || out_tready;
  assign do_modify  = (state_r == S_MODIFY) && out_free;
  assign first_old  = par_r ? odd_q : even_q;
  assign second_old = par_r ? even_q : odd_q;
  assign low_mask   = (64'd1 << off_r) - 64'd1;
  assign first_new  = (val_r << off_r) | (first_old & low_mask);
  assign second_new = (val_r >> (7'd64 - {1'b0, off_r})) | (second_old & ~low_mask);
  assign pos_sum    = {1'b0, pos_r} + {11'd0, wdt_r};
  assign pos_adv    = (pos_sum > {1'b0, POS_MAX}) ? POS_MAX : pos_sum[POS_W-1:0];

  // Bank write ports: clearing pass or write-back of the merged pair
  logic                 clearing;
  logic                 even_we;
  logic                 odd_we;
  logic [ROW_W-1:0]     even_waddr;
  logic [ROW_W-1:0]     odd_waddr;
  logic [WORD_W-1:0]    even_wdata;
  logic [WORD_W-1:0]    odd_wdata;

  assign clearing   = (state_r == S_CLEAR);
  assign even_we    = clearing || (do_modify && !refuse_r && (!par_r || spill_r));
  assign odd_we     = clearing || (do_modify && !refuse_r && (par_r || spill_r));
  assign even_waddr = clearing ? clr_row_r : even_addr_r;
  assign odd_waddr  = clearing ? clr_row_r : odd_addr_r;
  assign even_wdata = clearing ? '0 : (par_r ? second_new : first_new);
  assign odd_wdata  = clearing ? '0 : (par_r ? first_new : second_new);

  // Even bank
  always_ff @(posedge clk) begin
    if (even_we) begin
      mem_even[even_waddr] <= even_wdata;
    end
    if (in_fire) begin
      even_q <= mem_even[even_addr];
    end
  end

  // Odd bank
  always_ff @(posedge clk) begin
    if (odd_we) begin
      mem_odd[odd_waddr] <= odd_wdata;
    end
    if (in_fire) begin
      odd_q <= mem_odd[odd_addr];
    end
  end

  // Hold the request across the read cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      val_r       <= in_tdata[79:16];
      off_r       <= off;
      par_r       <= widx[0];
      spill_r     <= spill;
      refuse_r    <= refuse;
      wdt_r       <= in_wdt;
      even_addr_r <= even_addr;
      odd_addr_r  <= odd_addr;
    end
  end

  // Sequencer, configuration, position and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_row_r   <= '0;
      cap_r       <= CFG_RESET;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_row_r <= clr_row_r + 1'b1;
          if (clr_row_r == LAST_ROW) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_MODIFY;
          end
        end
        S_MODIFY: begin
          if (out_free) begin
            state_r       <= S_IDLE;
            out_valid_r   <= 1'b1;
            status_r      <= refuse_r ? STATUS_REFUSED : STATUS_WRITTEN;
            pos_out_r     <= refuse_r ? pos_r : pos_adv;
            first_out_r   <= refuse_r ? '0 : first_new;
            second_out_r  <= (refuse_r || !spill_r) ? '0 : second_new;
            spilled_out_r <= !refuse_r && spill_r;
            if (!refuse_r) begin
              pos_r <= pos_adv;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {6'd0, spilled_out_r, second_out_r, first_out_r, pos_out_r};

  // The running position never passes its ceiling
  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_MAX)
    else $error("running position above its maximum");

  // The position moves only when a written request completes its merge
  a_pos_moves_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(pos_r) |-> $past(do_modify && !refuse_r))
    else $error("position changed without a completed write");

  // An accepted request blocks the next one while its merge is pending
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("second request taken during merge");

  // A refused result never reports a spill
  a_refused_no_spill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == STATUS_REFUSED) |-> !spilled_out_r)
    else $error("refused result marked as spilled");

endmodule : bit_array_field_writer_top

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for bit_array_field_writer_top: predicts every result
// of the bit packer and checks it field by field. Depends on bafw_pkg and the top.
`default_nettype none

module testbench;
  import bafw_pkg::*;

  localparam int STORE_WORDS     = 1024;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int DRAIN_CYCLES    = 8;
  localparam bit MODE_APPEND     = 1'b0;
  localparam bit MODE_AT_INDEX   = 1'b1;

  // Expected result of one request
  typedef struct packed {
    logic              status;
    logic [POS_W-1:0]  position_after;
    logic [WORD_W-1:0] first_word_after;
    logic [WORD_W-1:0] second_word_after;
    logic              spilled;
  } packer_result_t;

  // Mirror of the packer state and the queue of results still to arrive
  class packer_scoreboard;
    logic [WORD_W-1:0] words [STORE_WORDS];
    int unsigned       bit_pos;
    int unsigned       capacity;
    packer_result_t    expected_q[$];
    int                failures;

    function new();
      foreach (words[i]) words[i] = '0;
      bit_pos  = 0;
      capacity = CFG_RESET;
      failures = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Work out the result of an accepted request and update the mirror
    function void note_request(bit mode, logic [IDX_W-1:0] idx, logic [WORD_W-1:0] val,
                               logic [WDT_W-1:0] wdt);
      int unsigned    eff_w, target, widx, off, eff_cap;
      bit             spill;
      logic [63:0]    low_mask;
      packer_result_t r;
      r       = '0;
      eff_w   = (wdt > WDT_MAX) ? WDT_MAX : wdt;
      target  = (mode == MODE_AT_INDEX) ? idx : bit_pos;
      widx    = target >> 6;
      off     = target & 63;
      spill   = (eff_w + off) > 64;
      eff_cap = (capacity > STORE_WORDS) ? STORE_WORDS : capacity;
      if (widx >= eff_cap || (spill && (widx + 1) >= eff_cap)) begin
        r.status         = STATUS_REFUSED;
        r.position_after = POS_W'(bit_pos);
      end else begin
        if (off == 0) begin
          words[widx]        = val;
          r.first_word_after = val;
        end else begin
          low_mask           = (64'd1 << off) - 64'd1;
          r.first_word_after = (val << off) | (words[widx] & low_mask);
          words[widx]        = r.first_word_after;
          if (spill) begin
            r.second_word_after = (val >> (64 - off)) | (words[widx + 1] & ~low_mask);
            words[widx + 1]     = r.second_word_after;
          end
        end
        bit_pos = bit_pos + eff_w;
        if (bit_pos > POS_MAX) bit_pos = POS_MAX;
        r.status         = STATUS_WRITTEN;
        r.position_after = POS_W'(bit_pos);
        r.spilled        = spill;
      end
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
        failures++;
      end
    endfunction

    // Compare an accepted result with the oldest expectation
    function void check_result(logic status, logic [OUT_TDATA_W-1:0] data);
      packer_result_t r;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding: status %0h data %0h", status, data);
        failures++;
        return;
      end
      r = expected_q.pop_front();
      compare_field("status", r.status, status);
      compare_field("position_after", r.position_after, data[16:0]);
      compare_field("first_word_after", r.first_word_after, data[80:17]);
      compare_field("second_word_after", r.second_word_after, data[144:81]);
      compare_field("spilled", r.spilled, data[145]);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [15:0] bit_index, [79:16] value, [86:80] width
  logic                   in_tuser = 1'b0; // [0] mode
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [16:0] position_after, [80:17] first_word_after, [144:81] second_word_after, [145] spilled
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;       // [0] status

  packer_scoreboard sb = new();
  bit sender_steady   = 1'b0;
  bit receiver_steady = 1'b0;
  int stall_left      = 0;
  int idle_count      = 0;

  bit_array_field_writer_top #(.CAPACITY_WORDS(STORE_WORDS)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Idle length: mostly short, a few long, none during a steady stretch
  function automatic int idle_len(inout bit steady);
    int r;
    if ($urandom_range(0, 99) < 3) steady = ~steady;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [WORD_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Width spans zero, the full word and the oversized codes
  function automatic logic [WDT_W-1:0] random_width();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return '0;
    if (r < 20) return WDT_W'($urandom_range(65, 127));
    if (r < 40) return WDT_MAX;
    return WDT_W'($urandom_range(1, 63));
  endfunction

  // Hold the receiver's ready low for random stretches
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      stall_left <= idle_len(receiver_steady);
      out_tready <= 1'b1;
    end
  end

  // Check each accepted result
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
  end

  // Abort when no channel moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Present one request and hold it until taken
  task automatic send_request(bit mode, logic [IDX_W-1:0] idx, logic [WORD_W-1:0] val,
                              logic [WDT_W-1:0] wdt);
    int gap;
    gap = idle_len(sender_steady);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {1'b0, wdt, val, idx};
    do @(posedge clk); while (!in_tready);
    sb.note_request(mode, idx, val, wdt);
  endtask

  // Drop the request line, drain, then write the capacity register
  task automatic set_capacity(logic [CFG_W-1:0] words_in_use);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= words_in_use;
    do @(posedge clk); while (!cfg_ready);
    sb.capacity = words_in_use;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random requests; mode-1 targets mostly land in the first span_words + 2 words
  task automatic run_random(int count, int append_pct, int span_words);
    bit               mode;
    logic [IDX_W-1:0] idx;
    int unsigned      hi;
    repeat (count) begin
      mode = ($urandom_range(0, 99) >= append_pct) ? MODE_AT_INDEX : MODE_APPEND;
      hi   = span_words * 64 + 127;
      if (hi > 65535) hi = 65535;
      idx  = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, hi));
      send_request(mode, idx, random_value(), random_width());
    end
  endtask

  // Append until the position reaches the end of the store, with scattered writes
  task automatic fill_store();
    logic [WDT_W-1:0] wdt;
    int unsigned      remaining, r;
    while (sb.bit_pos < POS_MAX) begin
      remaining = POS_MAX - sb.bit_pos;
      if ($urandom_range(0, 99) < 15) begin
        send_request(MODE_AT_INDEX, IDX_W'($urandom), random_value(), random_width());
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60)      wdt = WDT_MAX;
        else if (r < 70) wdt = WDT_W'($urandom_range(65, 127));
        else             wdt = WDT_W'($urandom_range(1, 63));
        if (((wdt > WDT_MAX) ? WDT_MAX : wdt) > remaining) wdt = WDT_W'(remaining);
        send_request(MODE_APPEND, IDX_W'($urandom), random_value(), wdt);
      end
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: edges of every field at the reset capacity
    send_request(MODE_APPEND, 16'hFFFF, '1, 7'd64);
    send_request(MODE_APPEND, 16'h0000, 64'h0123_4567_89AB_CDEF, 7'd0);
    send_request(MODE_APPEND, 16'h1234, 64'hA5A5_A5A5_A5A5_A5A5, 7'd127);
    send_request(MODE_APPEND, 16'h0000, 64'h0000_0000_0000_001F, 7'd5);
    send_request(MODE_APPEND, 16'h0000, '1, 7'd64);
    send_request(MODE_AT_INDEX, 16'hFFFF, '1, 7'd1);
    send_request(MODE_AT_INDEX, 16'hFFFF, '1, 7'd2);
    send_request(MODE_AT_INDEX, 16'hFFC0, 64'h5555_5555_5555_5555, 7'd64);
    send_request(MODE_AT_INDEX, 16'hFFC1, '1, 7'd64);
    send_request(MODE_AT_INDEX, 16'h0001, '0, 7'd64);
    send_request(MODE_AT_INDEX, 16'd63, '1, 7'd65);
    send_request(MODE_AT_INDEX, 16'h8000, 64'hDEAD_BEEF_0000_0001, 7'd0);
    send_request(MODE_AT_INDEX, 16'd100, '1, 7'd0);
    send_request(MODE_AT_INDEX, 16'd130, 64'hAAAA_AAAA_AAAA_AAAA, 7'd63);
    send_request(MODE_AT_INDEX, 16'd190, '1, 7'd2);
    send_request(MODE_APPEND, 16'hFFFF, 64'h8000_0000_0000_0000, 7'd96);

    // Single word in use: start and spill refusals
    set_capacity(11'd1);
    send_request(MODE_AT_INDEX, 16'd63, '1, 7'd1);
    send_request(MODE_AT_INDEX, 16'd63, '1, 7'd2);
    send_request(MODE_AT_INDEX, 16'd64, '1, 7'd1);
    run_random(90, 40, 1);

    // Nothing in use: every request refused
    set_capacity(11'd0);
    run_random(30, 40, 1);

    set_capacity(11'd2);
    run_random(90, 40, 2);

    set_capacity(11'($urandom_range(3, 1023)));
    run_random(120, 50, sb.capacity);

    // Full store: march the position to its limit
    set_capacity(11'd1024);
    fill_store();

    // Above the store size: clamps to the store, position stays saturated
    set_capacity(11'd2047);
    run_random(30, 50, STORE_WORDS);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
